>>> sv/periodic_setpoint_interpolator_unit_defines.svh
// Assertion macros for the setpoint interpolator.
`ifndef PERIODIC_SETPOINT_INTERPOLATOR_UNIT_DEFINES_SVH
`define PERIODIC_SETPOINT_INTERPOLATOR_UNIT_DEFINES_SVH
// Assert that a condition implies a consequence in the same cycle.
`define PSI_ASSERT_IMP(label, clk, rst_n, cond, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (cons)) \
		else $error(msg);
// Assert that a condition implies a consequence in the next cycle.
`define PSI_ASSERT_NEXT(label, clk, rst_n, cond, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (cons)) \
		else $error(msg);
`endif

>>> sv/psi_pkg.sv
// Shared types and constants of the setpoint interpolator.
`timescale 1ns / 1ps
package psi_pkg;
	localparam int TimeW = 32;
	localparam int ValW  = 32;
	localparam int IdxW  = 8;
	localparam int NumW  = 9;
	localparam int FracW = 16;
	localparam logic CmdLoad  = 1'b0;
	localparam logic CmdQuery = 1'b1;

	typedef struct packed {
		logic take_query;
		logic chk;
		logic start_mod;
		logic read_first;
		logic seg_init;
		logic seg_step;
		logic start_div;
		logic start_mul;
		logic res_zero;
		logic res_rd;
		logic res_interp;
		logic finish;
	} psi_cmd_t;

	typedef struct packed {
		logic mod_done;
		logic div_done;
		logic empty;
		logic need_mod;
		logic before_first;
		logic one_point;
		logic seg_adv;
		logic seg_last;
	} psi_stat_t;
endpackage

>>> sv/periodic_setpoint_interpolator_unit.sv
// Query path from acceptance to m_tvalid: a profile check, a modulo reduction when the
// time wraps, a breakpoint search, then a divide and a multiply; an empty profile, a
// single point or a time before the first point skip the search, and a time at or after
// the last point skips the divide. Flow: one transaction at a time; a query keeps the
// unit busy until its result is registered, which waits while an earlier result is untaken.
// Reset clears the controller, sets num_points to 1; table contents are undefined until loaded.
`timescale 1ns / 1ps
module periodic_setpoint_interpolator_unit #(
	parameter int TABLE_DEPTH = 256
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [103:0] s_tdata,  // entry_index, entry_time, entry_value, query_time
	input  logic         s_tuser,  // cmd
	output logic         m_tvalid,
	input  logic         m_tready,
	output logic [31:0]  m_tdata,  // setpoint
	output logic         m_tuser,  // empty_profile
	input  logic         cfg_we,
	input  logic [8:0]   cfg_wdata
);
	import psi_pkg::*;
	`include "periodic_setpoint_interpolator_unit_defines.svh"

	logic [NumW-1:0] num_q;
	psi_cmd_t  cmd;
	psi_stat_t stat;
	logic busy, in_fire;
	logic [ValW-1:0] res;
	logic res_emp;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			num_q <= NumW'(1);
		end else if (cfg_we) begin
			num_q <= cfg_wdata;
		end
	end

	assign s_tready = !busy;
	assign in_fire  = s_tvalid && s_tready;

	psi_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_fire(in_fire), .in_query(s_tuser == CmdQuery),
		.out_busy(m_tvalid && !m_tready), .stat(stat), .cmd(cmd), .busy(busy));

	psi_dp #(.TableDepth(TABLE_DEPTH)) u_dp (
		.clk(clk), .arst_n(arst_n),
		.load_we(in_fire && s_tuser == CmdLoad),
		.load_idx(s_tdata[7:0]), .load_time(s_tdata[39:8]), .load_val(s_tdata[71:40]),
		.query_time(s_tdata[103:72]), .num_points(num_q),
		.cmd(cmd), .stat(stat), .result(res), .result_empty(res_emp));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid <= 1'b0;
		end else if (cmd.finish) begin
			m_tvalid <= 1'b1;
		end else if (m_tready) begin
			m_tvalid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.finish) begin
			m_tdata <= res;
			m_tuser <= res_emp;
		end
	end

	`PSI_ASSERT_NEXT(a_out_hold, clk, arst_n, m_tvalid && !m_tready, m_tvalid, "result dropped")
	`PSI_ASSERT_NEXT(a_out_stable, clk, arst_n, m_tvalid && !m_tready, $stable(m_tdata) && $stable(m_tuser), "result changed")
	`PSI_ASSERT_IMP(a_no_take_busy, clk, arst_n, busy, !s_tready, "accepted while busy")
endmodule

>>> sv/psi_ram.sv
// Generic single-port-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module psi_ram #(
	parameter int Width = 32,
	parameter int Depth = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(Depth)-1:0] waddr,
	input  logic [Width-1:0]         wdata,
	input  logic [$clog2(Depth)-1:0] raddr,
	output logic [Width-1:0]         rdata
);
	logic [Width-1:0] mem [Depth];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

>>> sv/psi_ctrl.sv
// Controller state machine of the setpoint interpolator.
`timescale 1ns / 1ps
module psi_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_fire,
	input  logic              in_query,
	input  logic              out_busy,
	input  psi_pkg::psi_stat_t stat,
	output psi_pkg::psi_cmd_t  cmd,
	output logic              busy
);
	import psi_pkg::*;

	localparam logic [2:0] StIdle  = 3'd0;
	localparam logic [2:0] StChk   = 3'd1;
	localparam logic [2:0] StMod   = 3'd2;
	localparam logic [2:0] StFirst = 3'd3;
	localparam logic [2:0] StSeg   = 3'd4;
	localparam logic [2:0] StDiv   = 3'd5;
	localparam logic [2:0] StMul   = 3'd6;
	localparam logic [2:0] StOut   = 3'd7;

	logic [2:0] state_q, state_d;

	always_comb begin
		state_d = state_q;
		cmd = '0;
		unique case (state_q)
			StIdle: begin
				if (in_fire && in_query) begin
					cmd.take_query = 1'b1;
					state_d = StChk;
				end
			end
			StChk: begin
				cmd.chk = 1'b1;
				if (stat.empty) begin
					cmd.res_zero = 1'b1;
					state_d = StOut;
				end else if (stat.need_mod) begin
					cmd.start_mod = 1'b1;
					state_d = StMod;
				end else begin
					cmd.read_first = 1'b1;
					state_d = StFirst;
				end
			end
			StMod: begin
				if (stat.mod_done) begin
					cmd.read_first = 1'b1;
					state_d = StFirst;
				end
			end
			StFirst: begin
				cmd.seg_init = 1'b1;
				if (stat.before_first || stat.one_point) begin
					cmd.res_rd = 1'b1;
					state_d = StOut;
				end else begin
					state_d = StSeg;
				end
			end
			StSeg: begin
				if (stat.seg_adv) begin
					if (stat.seg_last) begin
						cmd.res_rd = 1'b1;
						state_d = StOut;
					end else begin
						cmd.seg_step = 1'b1;
					end
				end else begin
					cmd.start_div = 1'b1;
					state_d = StDiv;
				end
			end
			StDiv: begin
				if (stat.div_done) begin
					cmd.start_mul = 1'b1;
					state_d = StMul;
				end
			end
			StMul: begin
				cmd.res_interp = 1'b1;
				state_d = StOut;
			end
			StOut: begin
				if (!out_busy) begin
					cmd.finish = 1'b1;
					state_d = StIdle;
				end
			end
			default: state_d = StIdle;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= StIdle;
		end else begin
			state_q <= state_d;
		end
	end

	assign busy = (state_q != StIdle);
endmodule

>>> sv/psi_dp.sv
// Datapath of the setpoint interpolator: tables, search, modulo, divide, multiply.
`timescale 1ns / 1ps
module psi_dp #(
	parameter int TableDepth = 256
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       load_we,
	input  logic [psi_pkg::IdxW-1:0]   load_idx,
	input  logic [psi_pkg::TimeW-1:0]  load_time,
	input  logic [psi_pkg::ValW-1:0]   load_val,
	input  logic [psi_pkg::TimeW-1:0]  query_time,
	input  logic [psi_pkg::NumW-1:0]   num_points,
	input  psi_pkg::psi_cmd_t          cmd,
	output psi_pkg::psi_stat_t         stat,
	output logic [psi_pkg::ValW-1:0]   result,
	output logic                       result_empty
);
	import psi_pkg::*;

	localparam int AW = $clog2(TableDepth);
	localparam int CW = AW + 1;

	logic [AW-1:0]    raddr;
	logic [TimeW-1:0] trd;
	logic [ValW-1:0]  vrd;
	logic             we_ok;
	logic [AW-1:0]    waddr;

	assign we_ok = load_we && ({{(32-IdxW){1'b0}}, load_idx} < 32'(TableDepth));
	assign waddr = AW'(load_idx);

	psi_ram #(.Width(TimeW), .Depth(TableDepth)) u_time (
		.clk(clk), .we(we_ok), .waddr(waddr), .wdata(load_time),
		.raddr(raddr), .rdata(trd));
	psi_ram #(.Width(ValW), .Depth(TableDepth)) u_val (
		.clk(clk), .we(we_ok), .waddr(waddr), .wdata(load_val),
		.raddr(raddr), .rdata(vrd));

	// effective point count
	logic [CW-1:0] n_eff;
	always_comb begin
		if (num_points == '0) begin
			n_eff = CW'(1);
		end else if ({23'd0, num_points} > 32'(TableDepth)) begin
			n_eff = CW'(TableDepth);
		end else begin
			n_eff = CW'(num_points);
		end
	end
	logic [AW-1:0] last_idx;
	assign last_idx = AW'(n_eff - CW'(1));

	logic [TimeW-1:0] t_q, total_q, tl_q;
	logic [ValW-1:0]  vl_q;
	logic [AW-1:0]    i_q;
	logic [AW-1:0]    inext, iskip;
	assign inext = i_q + AW'(1);
	assign iskip = i_q + AW'(2);

	// modulo unit (restoring, 32 steps)
	logic [TimeW-1:0] rem_q, quo_q;
	logic [4:0]       mcnt_q;
	logic             mbusy_q;
	logic [TimeW:0]   msh, msub;
	logic [TimeW-1:0] mnext;
	assign msh   = {rem_q, quo_q[TimeW-1]};
	assign msub  = msh - {1'b0, total_q};
	assign mnext = (msh >= {1'b0, total_q}) ? msub[TimeW-1:0] : msh[TimeW-1:0];

	// fraction divider (dt < span, 16 quotient bits)
	logic [TimeW-1:0] span_q, drem_q;
	logic [FracW-1:0] frac_q;
	logic [3:0]       dcnt_q;
	logic             dbusy_q;
	logic [TimeW:0]   dsh, dsub;
	logic             dge;
	assign dsh  = {drem_q, 1'b0};
	assign dsub = dsh - {1'b0, span_q};
	assign dge  = (dsh >= {1'b0, span_q});

	logic signed [ValW:0]         delta_q;
	logic signed [ValW+FracW+1:0] prod_q;

	logic [ValW-1:0] res_q;
	logic            emp_q;

	always_comb begin
		if (cmd.take_query) begin
			raddr = last_idx;
		end else if (cmd.read_first) begin
			raddr = '0;
		end else if (cmd.seg_step) begin
			raddr = iskip;
		end else begin
			raddr = inext;
		end
	end

	assign stat.mod_done     = !mbusy_q;
	assign stat.div_done     = !dbusy_q;
	assign stat.empty        = (trd == '0);
	assign stat.need_mod     = (t_q > trd);
	assign stat.before_first = (t_q < trd);
	assign stat.one_point    = (last_idx == '0);
	assign stat.seg_adv      = (trd <= t_q);
	assign stat.seg_last     = (inext == last_idx);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mbusy_q <= 1'b0;
			dbusy_q <= 1'b0;
		end else begin
			if (cmd.start_mod) mbusy_q <= 1'b1;
			else if (mbusy_q && mcnt_q == 5'd31) mbusy_q <= 1'b0;
			if (cmd.start_div) dbusy_q <= 1'b1;
			else if (dbusy_q && dcnt_q == 4'd15) dbusy_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.take_query) begin
			t_q <= query_time;
			i_q <= '0;
		end else begin
			if (mbusy_q && mcnt_q == 5'd31) t_q <= (mnext == '0) ? total_q : mnext;
			if (cmd.seg_step) i_q <= inext;
		end
		if (cmd.chk) total_q <= trd;
		if (cmd.start_mod) begin
			rem_q  <= '0;
			quo_q  <= t_q;
			mcnt_q <= '0;
		end else if (mbusy_q) begin
			rem_q  <= mnext;
			quo_q  <= {quo_q[TimeW-2:0], 1'b0};
			mcnt_q <= mcnt_q + 5'd1;
		end
		if (cmd.seg_init || cmd.seg_step) begin
			tl_q <= trd;
			vl_q <= vrd;
		end
		if (cmd.start_div) begin
			span_q  <= trd - tl_q;
			drem_q  <= t_q - tl_q;
			dcnt_q  <= '0;
			delta_q <= $signed({vrd[ValW-1], vrd}) - $signed({vl_q[ValW-1], vl_q});
		end else if (dbusy_q) begin
			drem_q <= dge ? dsub[TimeW-1:0] : dsh[TimeW-1:0];
			frac_q <= {frac_q[FracW-2:0], dge};
			dcnt_q <= dcnt_q + 4'd1;
		end
		if (cmd.start_mul) prod_q <= delta_q * $signed({1'b0, frac_q});
		if (cmd.res_zero) begin
			res_q <= '0;
			emp_q <= 1'b1;
		end else if (cmd.res_rd) begin
			res_q <= vrd;
			emp_q <= 1'b0;
		end else if (cmd.res_interp) begin
			res_q <= vl_q + prod_q[ValW+FracW-1:FracW];
			emp_q <= 1'b0;
		end
	end

	assign result = res_q;
	assign result_empty = emp_q;
endmodule
